// ----- src/lccd_pkg.sv -----
package lccd_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM,
        ST_SIN_Z2,
        ST_SIN_T1,
        ST_SIN_T2,
        ST_SIN_S,
        ST_ACC,
        ST_MAG,
        ST_SQX,
        ST_SQY,
        ST_DEN,
        ST_DIV,
        ST_UPDATE,
        ST_OUT
    } state_t;

    localparam int RANGE_W = 14;
    localparam int ANGLE_W = 16;
    localparam int INDEX_W = 12;
    localparam int CURV_W  = 32;
    localparam int ACC_W   = 40;
    localparam int NUM_W   = 72;
    localparam int DEN_W   = 28;

endpackage

// ----- src/lccd_div.sv -----
// Restoring divider: one quotient bit per cycle.
module lccd_div
    import lccd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [NUM_W-1:0]   numer,
    input  logic [DEN_W-1:0]   denom,
    output logic               busy,
    output logic               done,
    output logic [NUM_W-1:0]   quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] diff;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
        diff  = {1'b0, trial} - {2'b00, den_reg};
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W+1])
            begin
                rem_next  = diff[DEN_W:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- src/lidar_curvature_corner_detect_top.sv -----
// Corner detector for one boundary run of lidar samples. A sample that
// completes a window keeps the block busy until its curvature has been
// evaluated, and no new sample is taken while the block is busy. One shared
// 32x32 multiplier runs the four-step sine polynomial and the range product
// for the sine and the cosine of each of the 2*HALF_WINDOW neighbour terms.
// It then forms the squared centre range and the two squares. A restoring
// divider holds the sequencer in the divide state until the quotient is done.
// Samples that do not complete a window, have zero centre range, or lie past
// MAX_POINTS go from the term state straight to the update state. A sample
// with tlast set then passes through the output state to hand over its result
// transaction, and waits there while the previous result still waits. The
// result transaction holds the first greatest curvature and its run position.
module lidar_curvature_corner_detect_top
    import lccd_pkg::*;
#(
    parameter int HALF_WINDOW = 9,
    parameter int MAX_POINTS  = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // range_q[13:0], angle_q[29:14], zero fill
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // corner_index[11:0], curvature_max[43:12], found[44]
    output logic        m_tlast
);

    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int WIN_W   = $clog2(WIN_LEN);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);

    logic [RANGE_W-1:0] rwin_reg [WIN_LEN];
    logic [ANGLE_W-1:0] awin_reg [WIN_LEN];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CURV_W-1:0]  best_reg, best_next;
    logic [INDEX_W-1:0] bidx_reg, bidx_next;
    logic               last_reg, last_next;
    logic               eval_reg, eval_next;
    state_t             state_reg, state_next;
    logic [WIN_W-1:0]   k_reg, k_next;
    logic               cos_reg, cos_next;
    logic signed [ACC_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [14:0]        z_reg, z_next;
    logic               neg_reg, neg_next;
    logic [31:0]        p_reg, p_next;    // polynomial intermediate
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic [31:0]        mx_reg, mx_next, my_reg, my_next;
    logic [CURV_W-1:0]  curv_reg, curv_next;
    logic [CURV_W-1:0]  ocurv_reg, ocurv_next;
    logic [INDEX_W-1:0] oidx_reg, oidx_next;
    logic               ovalid_reg, ovalid_next;

    // Shared multiplier.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic               div_start, div_busy, div_done;
    logic [NUM_W-1:0]   div_quot;

    lccd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (num_reg),
        .denom (den_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    logic [RANGE_W-1:0] rc, ri;
    logic [ANGLE_W-1:0] ac, dang;
    logic [15:0]        darg;
    logic [ACC_W-1:0]   prod;
    logic signed [ACC_W-1:0] term;
    logic [ACC_W-1:0]   dxm, dym;
    logic [NUM_W-1:0]   qsh;

    assign rc   = rwin_reg[HALF_WINDOW];
    assign ac   = awin_reg[HALF_WINDOW];
    assign ri   = rwin_reg[k_reg];
    assign dang = awin_reg[k_reg] - ac;
    assign darg = cos_reg ? dang + 16'h4000 : dang;
    // The range times the sine magnitude needs at most 30 bits.
    assign prod = ACC_W'(mul_p[29:0]);
    assign term = neg_reg ? -$signed(prod) : $signed(prod);
    assign dxm  = dx_reg[ACC_W-1] ? ACC_W'(-dx_reg) : ACC_W'(dx_reg);
    assign dym  = dy_reg[ACC_W-1] ? ACC_W'(-dy_reg) : ACC_W'(dy_reg);
    assign qsh  = div_quot >> 4;

    logic in_fire, out_fire;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                    state_next = ST_TERM;
            ST_TERM:
                if (!eval_reg || count_reg < CNT_W'(2 * HALF_WINDOW + 1))
                    state_next = ST_UPDATE;
                else if (rc == '0)
                    state_next = ST_UPDATE;
                else
                    state_next = ST_SIN_Z2;
            ST_SIN_Z2: state_next = ST_SIN_T1;
            ST_SIN_T1: state_next = ST_SIN_T2;
            ST_SIN_T2: state_next = ST_SIN_S;
            ST_SIN_S:  state_next = ST_ACC;
            ST_ACC:
                if (cos_reg && k_reg == WIN_W'(WIN_LEN - 1))
                    state_next = ST_MAG;
                else
                    state_next = ST_SIN_Z2;
            ST_MAG:    state_next = ST_SQX;
            ST_SQX:    state_next = ST_SQY;
            ST_SQY:    state_next = ST_DEN;
            ST_DEN:    state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                state_next = last_reg ? ST_OUT : ST_IDLE;
            ST_OUT:
                if (!ovalid_reg || out_fire)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        count_next = count_reg;
        best_next  = best_reg;
        bidx_next  = bidx_reg;
        last_next  = last_reg;
        eval_next  = eval_reg;
        k_next     = k_reg;
        cos_next   = cos_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        z_next     = z_reg;
        neg_next   = neg_reg;
        p_next     = p_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        mx_next    = mx_reg;
        my_next    = my_reg;
        curv_next  = curv_reg;
        ocurv_next = ocurv_reg;
        oidx_next  = oidx_reg;
        ovalid_next = ovalid_reg;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        if (out_fire)
            ovalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire)
                begin
                    last_next = s_tlast;
                    // Only samples that enter the window are evaluated.
                    eval_next = (count_reg < CNT_W'(MAX_POINTS));
                    if (count_reg < CNT_W'(MAX_POINTS))
                        count_next = count_reg + 1'b1;
                end
            ST_TERM:
            begin
                k_next    = '0;
                cos_next  = 1'b0;
                dx_next   = '0;
                dy_next   = '0;
                curv_next = '0;
            end
            ST_SIN_Z2:
            begin
                z_next   = darg[14] ? 15'd16384 - {1'b0, darg[13:0]} : {1'b0, darg[13:0]};
                neg_next = darg[15];
                mul_a = 32'(darg[14] ? 15'd16384 - {1'b0, darg[13:0]} : {1'b0, darg[13:0]});
                mul_b = mul_a;
                p_next = 32'(mul_p >> 14);
            end
            ST_SIN_T1:
            begin
                mul_a = p_reg;
                mul_b = 32'd2320;
                num_next = NUM_W'(p_reg);   // keep z2
                p_next = 32'(mul_p >> 14);
            end
            ST_SIN_T2:
            begin
                mul_a = 32'd21024 - p_reg;
                mul_b = 32'(num_reg);
                p_next = 32'(mul_p >> 14);
            end
            ST_SIN_S:
            begin
                mul_a = 32'd51472 - p_reg;
                mul_b = 32'(z_reg);
                p_next = 32'(mul_p >> 14);
            end
            ST_ACC:
            begin
                mul_a = 32'(ri);
                mul_b = 32'(p_reg[15:0]);
                if (cos_reg)
                    dx_next = dx_reg + $signed(ACC_W'(rc) << 15) - term;
                else
                    dy_next = dy_reg + term;
                if (cos_reg)
                begin
                    cos_next = 1'b0;
                    if (k_reg + 1'b1 == WIN_W'(HALF_WINDOW))
                        k_next = k_reg + WIN_W'(2);
                    else
                        k_next = k_reg + 1'b1;
                end
                else
                    cos_next = 1'b1;
            end
            ST_MAG:
            begin
                mul_a = 32'(rc);
                mul_b = 32'(rc);
                den_next = DEN_W'(mul_p);
                mx_next = 32'(dxm >> 5);
                my_next = 32'(dym >> 5);
            end
            ST_SQX:
            begin
                mul_a = mx_reg;
                mul_b = mx_reg;
                num_next = NUM_W'(mul_p);
            end
            ST_SQY:
            begin
                mul_a = my_reg;
                mul_b = my_reg;
                num_next = num_reg + NUM_W'(mul_p);
            end
            ST_DEN:
                div_start = 1'b1;
            ST_DIV:
                if (div_done)
                    curv_next = (qsh[NUM_W-1:CURV_W] != '0) ? '1 : qsh[CURV_W-1:0];
            ST_UPDATE:
            begin
                // Samples that were not evaluated carry a zero curvature.
                if (curv_reg > best_reg)
                begin
                    best_next = curv_reg;
                    bidx_next = INDEX_W'(count_reg - 1'b1 - CNT_W'(HALF_WINDOW));
                end
                curv_next = '0;
            end
            ST_OUT:
                if (!ovalid_reg || out_fire)
                begin
                    ovalid_next = 1'b1;
                    ocurv_next  = best_reg;
                    oidx_next   = bidx_reg;
                    best_next   = '0;
                    bidx_next   = '0;
                    count_next  = '0;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            best_reg   <= '0;
            bidx_reg   <= '0;
            ovalid_reg <= 1'b0;
            eval_reg   <= 1'b0;
            for (int i = 0; i < WIN_LEN; i++)
            begin
                rwin_reg[i] <= '0;
                awin_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            best_reg   <= best_next;
            bidx_reg   <= bidx_next;
            ovalid_reg <= ovalid_next;
            eval_reg   <= eval_next;
            if (in_fire && count_reg < CNT_W'(MAX_POINTS))
            begin
                for (int i = 0; i < WIN_LEN - 1; i++)
                begin
                    rwin_reg[i] <= rwin_reg[i+1];
                    awin_reg[i] <= awin_reg[i+1];
                end
                rwin_reg[WIN_LEN-1] <= s_tdata[13:0];
                awin_reg[WIN_LEN-1] <= s_tdata[29:14];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg  <= last_next;
        k_reg     <= k_next;
        cos_reg   <= cos_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        z_reg     <= z_next;
        neg_reg   <= neg_next;
        p_reg     <= p_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
        curv_reg  <= curv_next;
        ocurv_reg <= ocurv_next;
        oidx_reg  <= oidx_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tlast  = 1'b1;
    assign m_tdata  = {3'b000, (ocurv_reg != '0), ocurv_reg, oidx_reg};

    property p_out_only_from_out;
        @(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT;
    endproperty
    a_out_only_from_out: assert property (p_out_only_from_out)
        else $error("result raised outside output state");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("accepted while busy");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ST_DIV))
        else $error("divider running outside divide state");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("sample count past cap");

endmodule

// ----- dv/lidar_curvature_corner_detect_top_tb.sv -----
module lidar_curvature_corner_detect_top_tb
    import lccd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF = 9;
    localparam int WIN = 2 * HALF + 1;
    localparam int PTS_MAX = 4096;
    localparam int N_ITEMS = 2000;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [INDEX_W-1:0] idx;
        logic [CURV_W-1:0]  curv;
        logic               found;
    } corner_t;

    typedef struct {
        logic [RANGE_W-1:0] rng;
        logic [ANGLE_W-1:0] ang;
        logic               last;
        logic               typed;
        logic [INDEX_W-1:0] idx;
        logic [CURV_W-1:0]  curv;
        logic               found;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    lidar_curvature_corner_detect_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // Predictor state: sliding window and running best of the current run.
    logic [RANGE_W-1:0] rng_win [WIN];
    logic [ANGLE_W-1:0] ang_win [WIN];
    int unsigned        run_pos;
    logic [CURV_W-1:0]  best_curv;
    logic [INDEX_W-1:0] best_idx;

    corner_t corners_due[$];
    int      items_sent;
    int      corners_seen;
    int      runs_sent;
    int      errors;
    int      idle_cycles;

    function automatic int sine_q15(logic [15:0] d);
        longint unsigned z, z2, t, s;
        z = 64'(d[13:0]);
        if (d[14])
            z = 16384 - z;
        z2 = (z * z) >> 14;
        t = (2320 * z2) >> 14;
        t = ((21024 - t) * z2) >> 14;
        s = ((51472 - t) * z) >> 14;
        return d[15] ? -int'(s) : int'(s);
    endfunction

    function automatic logic [CURV_W-1:0] centre_curv();
        longint dx, dy;
        longint unsigned mx, my, n, den, q;
        logic [15:0] d, dc;
        longint rc;
        dx = 0;
        dy = 0;
        rc = longint'(rng_win[HALF]);
        if (rc == 0)
            return '0;
        for (int k = 0; k < WIN; k++) begin
            if (k != HALF) begin
                d = ang_win[k] - ang_win[HALF];
                dc = d + 16'h4000;
                dx += (rc << 15) - longint'(rng_win[k]) * sine_q15(dc);
                dy += longint'(rng_win[k]) * sine_q15(d);
            end
        end
        mx = (dx < 0 ? -dx : dx) >> 5;
        my = (dy < 0 ? -dy : dy) >> 5;
        n = mx * mx + my * my;
        den = rc * rc;
        q = (n / den) >> 4;
        return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic bit track_sample(logic [RANGE_W-1:0] r, logic [ANGLE_W-1:0] a,
                                        logic l, output corner_t res);
        logic [CURV_W-1:0] c;
        if (run_pos < PTS_MAX) begin
            for (int k = 0; k < WIN - 1; k++) begin
                rng_win[k] = rng_win[k+1];
                ang_win[k] = ang_win[k+1];
            end
            rng_win[WIN-1] = r;
            ang_win[WIN-1] = a;
            if (run_pos >= 2 * HALF) begin
                c = centre_curv();
                if (c > best_curv) begin
                    best_curv = c;
                    best_idx = INDEX_W'(run_pos - HALF);
                end
            end
            run_pos++;
        end
        res.idx = best_idx;
        res.curv = best_curv;
        res.found = (best_curv != 0);
        if (!l)
            return 1'b0;
        run_pos = 0;
        best_curv = '0;
        best_idx = '0;
        return 1'b1;
    endfunction

    function automatic int gap_len();
        int p;
        if ((items_sent >= 300 && items_sent < 500) || (items_sent >= 1500 && items_sent < 1700))
            return 0;
        p = $urandom_range(0, 99);
        if (p < 70)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_sample(logic [RANGE_W-1:0] r, logic [ANGLE_W-1:0] a, logic l,
                               bit typed = 0, corner_t typed_res = '{default: '0});
        int g;
        corner_t res;
        corner_t due;
        g = gap_len();
        repeat (g) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, a, r};
        s_tlast  <= l;
        forever begin
            @(posedge clk);
            if (s_tready)
                break;
        end
        items_sent++;
        if (track_sample(r, a, l, res)) begin
            runs_sent++;
            due = typed ? typed_res : res;
            corners_due.insert(corners_due.size(), due);
        end
    endtask

    // Receiver: ready drops for random stretches, quiet during no-idle phases.
    initial begin
        int n;
        forever begin
            n = gap_len();
            if (n > 0) begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        corner_t want;
        if (rst_n && m_tvalid && m_tready) begin
            corners_seen++;
            if (corners_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transaction: %h", m_tdata);
            end else begin
                want = corners_due.pop_front();
                if (m_tdata[11:0] !== want.idx || m_tdata[43:12] !== want.curv ||
                    m_tdata[44] !== want.found) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: want idx %0d curv %h found %0d, got idx %0d curv %h found %0d",
                                 want.idx, want.curv, want.found,
                                 m_tdata[11:0], m_tdata[43:12], m_tdata[44]);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d results outstanding", corners_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Directed rows: the extremes of both fields, short runs, and a run of twenty
    // whose first centre has zero range and whose second has full range.
    stim_row_t dir_rows [25] = '{
        '{14'd16383, 16'h8000, 1'b1, 1'b1, 12'd0, 32'd0, 1'b0},
        '{14'd0,     16'h7FFF, 1'b0, 1'b1, 12'd0, 32'd0, 1'b0},
        '{14'd16383, 16'h0000, 1'b0, 1'b1, 12'd0, 32'd0, 1'b0},
        '{14'd1,     16'hFFFF, 1'b1, 1'b1, 12'd0, 32'd0, 1'b0},
        '{14'd16383, 16'h8000, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd16383, 16'h7FFF, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd0,     16'h0000, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd8192,  16'h4000, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd1,     16'hC000, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd16383, 16'h2000, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd12000, 16'h1000, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd4000,  16'hF000, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd16383, 16'h0800, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd0,     16'h0000, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd16383, 16'h0010, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd16383, 16'h8000, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd2,     16'h7FFF, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd16383, 16'h3FFF, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd9000,  16'hBFFF, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd16383, 16'hFFFF, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd0,     16'h0001, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd16383, 16'h5555, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd10922, 16'hAAAA, 1'b0, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd16383, 16'h4001, 1'b1, 1'b0, 12'd0, 32'd0, 1'b0},
        '{14'd16383, 16'h8000, 1'b1, 1'b1, 12'd0, 32'd0, 1'b0}
    };

    initial begin
        int len, rmode, base, step, step2, turn, wait_cnt;
        int rconst;
        int a_val;
        logic [RANGE_W-1:0] r;
        bit drained;
        items_sent = 0;
        corners_seen = 0;
        runs_sent = 0;
        errors = 0;
        drained = 0;
        run_pos = 0;
        best_curv = '0;
        best_idx = '0;
        for (int k = 0; k < WIN; k++) begin
            rng_win[k] = '0;
            ang_win[k] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_sample(dir_rows[i].rng, dir_rows[i].ang, dir_rows[i].last, dir_rows[i].typed,
                        '{dir_rows[i].idx, dir_rows[i].curv, dir_rows[i].found});

        while (items_sent < N_ITEMS) begin
            if (!drained && items_sent >= N_ITEMS / 2) begin
                // Hold the sender until every outstanding result has arrived.
                drained = 1;
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (corners_due.size() != 0)
                    @(negedge clk);
            end
            // Mostly full windows; short runs act as broken sequences.
            if ($urandom_range(0, 9) < 2)
                len = $urandom_range(1, 2 * HALF);
            else
                len = $urandom_range(WIN, WIN + 9);
            rmode = $urandom_range(0, 3);
            rconst = $urandom_range(0, 16383);
            base = $urandom_range(0, 65535);
            step = $urandom_range(0, 1) ? $urandom_range(0, 600) - 300 : $urandom_range(0, 65535);
            step2 = $urandom_range(0, 600) - 300;
            turn = $urandom_range(0, len);
            for (int k = 0; k < len; k++) begin
                case (rmode)
                    0: r = RANGE_W'($urandom_range(0, 16383));
                    1: r = RANGE_W'(rconst);
                    2: r = RANGE_W'($urandom_range(0, 3));
                    default: r = $urandom_range(0, 1) ? 14'd16383 : 14'd0;
                endcase
                if (rmode == 1)
                    a_val = base + k * step;
                else
                    a_val = base + ((k < turn) ? k * step : turn * step + (k - turn) * step2)
                            + $urandom_range(0, 15) - 8;
                send_sample(r, a_val[15:0], (k == len - 1));
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        wait_cnt = 0;
        while (corners_due.size() != 0 && wait_cnt < STALL_LIMIT) begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (1000) @(posedge clk);
        if (corners_due.size() != 0)
            errors++;

        $display("sent %0d samples in %0d runs, checked %0d corner results",
                 items_sent, runs_sent, corners_seen);
        $display("mismatch count %0d", errors);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/lccd_pkg.sv
src/lccd_div.sv
src/lidar_curvature_corner_detect_top.sv
dv/lidar_curvature_corner_detect_top_tb.sv
